### sv/lfr_pkg.sv
// Shared types and constants for the letter frequency ranker.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package lfr_pkg;

  // Alphabet and field widths.
  localparam int NUM_LETTERS   = 26;
  localparam int LETTER_W      = 5;
  localparam int CHAR_W        = 8;
  localparam int OUT_COUNT_W   = 16;
  localparam int COUNT_W_DEF   = 16;
  localparam int FIFO_DEPTH_DEF = 4;

  // Largest count that the result field can show.
  localparam logic [31:0] OUT_COUNT_MAX = 32'h0000_FFFF;

  // Character bounds.
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

  // Operation codes of an input beat.
  localparam logic OP_COUNT  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Classified item passed from the front end through the queue.
  typedef struct packed {
    logic                report;
    logic [LETTER_W-1:0] letter;
  } lfr_item_t;

endpackage
`default_nettype wire

### sv/lfr_front.sv
// Front end: classifies each input beat into a letter increment or a report request.
// Depends on lfr_pkg. Non-letter characters are dropped here.
`default_nettype none
module lfr_front (
  input  wire logic                      operation,
  input  wire logic [lfr_pkg::CHAR_W-1:0] char_code,
  output lfr_pkg::lfr_item_t             item,
  output logic                           keep
);
  import lfr_pkg::*;

  logic is_upper;
  logic is_lower;
  logic [CHAR_W-1:0] offset;

  // Map both cases onto letter indexes 0 to 25.
  always_comb begin
    is_upper = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_Z);
    is_lower = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_Z);
    offset   = is_upper ? (char_code - CHAR_UPPER_A) : (char_code - CHAR_LOWER_A);
    item.report = (operation == OP_REPORT);
    item.letter = offset[LETTER_W-1:0];
    keep        = (operation == OP_REPORT) || is_upper || is_lower;
  end

endmodule
`default_nettype wire

### sv/lfr_fifo.sv
// Short queue between the front end and the counting back end.
// Depends on lfr_pkg for the item type.
`default_nettype none
module lfr_fifo #(
  parameter int DEPTH = lfr_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  lfr_pkg::lfr_item_t      push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    not_empty,
  output lfr_pkg::lfr_item_t      head
);
  import lfr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lfr_item_t         slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full      = (fill == FULL_CNT);
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  // Storage is written at the tail; no reset is needed for payload.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### sv/lfr_back.sv
// Back end: letter counters, the ranking scan and the result register.
// Depends on lfr_pkg. Each result is found by one scan over all 26 counters.
`default_nettype none
module lfr_back #(
  parameter int COUNT_WIDTH = lfr_pkg::COUNT_W_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  input  lfr_pkg::lfr_item_t                 item,
  output logic                               item_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lfr_pkg::LETTER_W-1:0]       letter,
  output logic [lfr_pkg::OUT_COUNT_W-1:0]    count,
  output logic                               last
);
  import lfr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [LETTER_W-1:0]    LAST_LETTER = LETTER_W'(NUM_LETTERS - 1);

  state_t                  state;
  logic [COUNT_WIDTH-1:0]  counts [NUM_LETTERS];
  logic [NUM_LETTERS-1:0]  reported;
  logic [LETTER_W-1:0]     scan_idx;
  logic [COUNT_WIDTH-1:0]  best_cnt;
  logic [LETTER_W-1:0]     best_idx;
  logic                    best_found;

  logic [LETTER_W-1:0]     rd_addr;
  logic [COUNT_WIDTH-1:0]  rd_data;
  logic                    take;
  logic                    best_cnt_en;
  logic [COUNT_WIDTH-1:0]  best_cnt_next;
  logic [LETTER_W-1:0]     best_idx_next;
  logic                    best_found_next;
  logic [NUM_LETTERS-1:0]  nonzero;
  logic [NUM_LETTERS-1:0]  best_bit;
  logic [31:0]             best_wide;

  // One shared read port: scan position while ranking, queued letter otherwise.
  assign rd_addr  = (state == ST_SCAN) ? scan_idx : item.letter;
  assign rd_data  = counts[rd_addr];
  assign item_pop = (state == ST_IDLE) && item_valid;
  assign out_valid = (state == ST_EMIT);

  // Nonzero flags of all counters, used to decide the last result.
  always_comb begin
    for (int i = 0; i < NUM_LETTERS; i++) begin
      nonzero[i] = (counts[i] != '0);
    end
  end

  // Scan step: a strictly larger unreported count wins, so ties keep the earlier letter.
  always_comb begin
    take            = !reported[scan_idx] && (rd_data > best_cnt);
    best_cnt_en     = take;
    best_cnt_next   = take ? rd_data  : best_cnt;
    best_idx_next   = take ? scan_idx : best_idx;
    best_found_next = take || best_found;
    best_bit        = NUM_LETTERS'(1) << best_idx_next;
    best_wide       = 32'(best_cnt_next);
  end

  // Counters: increment with saturation, cleared after the last beat of a report.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LETTERS; i++) begin
        counts[i] <= '0;
      end
    end else if (state == ST_EMIT && out_ready && last) begin
      for (int i = 0; i < NUM_LETTERS; i++) begin
        counts[i] <= '0;
      end
    end else if (item_pop && !item.report && rd_data != COUNT_MAX) begin
      counts[item.letter] <= rd_data + 1'b1;
    end
  end

  // Ranking sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      reported   <= '0;
      scan_idx   <= '0;
      best_cnt   <= '0;
      best_idx   <= '0;
      best_found <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_pop && item.report) begin
            state      <= ST_SCAN;
            reported   <= '0;
            scan_idx   <= '0;
            best_cnt   <= '0;
            best_idx   <= '0;
            best_found <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (best_cnt_en) begin
            best_cnt <= best_cnt_next;
            best_idx <= best_idx_next;
          end
          best_found <= best_found_next;
          if (scan_idx == LAST_LETTER) begin
            state <= ST_EMIT;
            if (best_found_next) begin
              reported <= reported | best_bit;
            end
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            if (last) begin
              state    <= ST_IDLE;
              reported <= '0;
            end else begin
              state      <= ST_SCAN;
              scan_idx   <= '0;
              best_cnt   <= '0;
              best_idx   <= '0;
              best_found <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result register, loaded as a scan finishes; an empty report gives letter A, count 0.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && scan_idx == LAST_LETTER) begin
      if (best_found_next) begin
        letter <= best_idx_next;
        count  <= (best_wide > OUT_COUNT_MAX) ? OUT_COUNT_MAX[OUT_COUNT_W-1:0]
                                              : best_wide[OUT_COUNT_W-1:0];
        last   <= ((nonzero & ~reported & ~best_bit) == '0);
      end else begin
        letter <= '0;
        count  <= '0;
        last   <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### sv/letter_frequency_ranker.sv
// Letter frequency ranker: top level joining front end, queue and back end.
// Depends on lfr_pkg, lfr_front, lfr_fifo and lfr_back.
//
// Usage: input beats carry operation and char_code on a valid/ready channel.
// A count beat (operation 0) adds one to the counter of its letter, either case;
// other bytes are dropped. A report beat (operation 1) yields one output beat per
// letter with a nonzero count, largest count first, equal counts alphabetically,
// with last set on the final beat; then all counters clear. With no letters seen
// the report yields one beat: letter 0, count 0, last set.
// Throughput: the back end retires one count beat per cycle from the queue while no
// report is being ranked. Each report result takes one scan of all 26 counters and
// then waits in the result register until the receiver takes it.
// The input stays ready while the queue (FIFO_DEPTH entries) has room, also while
// a result waits; when the receiver stalls the result holds and the queue fills.
// Reset: synchronous, clears counters, queue and sequencer; no clearing pass.
`default_nettype none
module letter_frequency_ranker #(
  parameter int COUNT_WIDTH = lfr_pkg::COUNT_W_DEF,
  parameter int FIFO_DEPTH  = lfr_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          operation,
  input  wire logic [lfr_pkg::CHAR_W-1:0]    char_code,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lfr_pkg::LETTER_W-1:0]       letter,
  output logic [lfr_pkg::OUT_COUNT_W-1:0]    count,
  output logic                               last
);
  import lfr_pkg::*;

  lfr_item_t front_item;
  lfr_item_t head_item;
  logic      keep;
  logic      fifo_full;
  logic      fifo_not_empty;
  logic      fifo_pop;

  assign in_ready = !fifo_full;

  // Classify the incoming beat.
  lfr_front u_front (
    .operation (operation),
    .char_code (char_code),
    .item      (front_item),
    .keep      (keep)
  );

  // Queue between classification and counting.
  lfr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready && keep),
    .push_item (front_item),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .not_empty (fifo_not_empty),
    .head      (head_item)
  );

  // Counting and ranking.
  lfr_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (fifo_not_empty),
    .item       (head_item),
    .item_pop   (fifo_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .letter     (letter),
    .count      (count),
    .last       (last)
  );

`ifndef SYNTH
  // Only the final beat of a report may carry a zero count.
  a_zero_only_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && count == '0) |-> last)
    else $error("zero count on a beat that is not last");

  // The empty report names letter A.
  a_empty_letter: assert property (@(posedge clk) disable iff (rst)
    (out_valid && count == '0) |-> (letter == '0))
    else $error("empty report with nonzero letter");

  // After the last beat the sequencer returns to idle, so no beat follows at once.
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> !out_valid)
    else $error("result presented right after the last beat");
`endif

endmodule
`default_nettype wire

### test/letter_frequency_ranker_tb.sv
// Self-checking testbench for the letter frequency ranker: directed and random beats,
// with results predicted in the bench and checked beat by beat.
// Depends on lfr_pkg and letter_frequency_ranker.
`timescale 1ns / 1ps
`default_nettype none
module letter_frequency_ranker_tb;
  import lfr_pkg::*;

  // One expected beat of a ranked report.
  typedef struct {
    logic [LETTER_W-1:0]    letter;
    logic [OUT_COUNT_W-1:0] count;
    logic                   last;
  } ranked_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = OP_COUNT;
  logic [CHAR_W-1:0] char_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LETTER_W-1:0] letter;
  logic [OUT_COUNT_W-1:0] count;
  logic last;

  // Bench copy of the letter counters and the queue of ranked beats still to arrive.
  logic [OUT_COUNT_W-1:0] tally [NUM_LETTERS];
  ranked_entry_t ranked_q[$];
  int fails = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold = 0;
  int rx_phase_left = 0;
  ranked_entry_t want;

  letter_frequency_ranker i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .letter    (letter),
    .count     (count),
    .last      (last)
  );

  // Clock with an 8 ns period.
  always #4 clk = ~clk;

  // Idle length: mostly none, sometimes a few cycles, now and then a long gap.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Adds one character to the bench counters; non-letters leave them alone.
  function automatic void tally_char(logic [CHAR_W-1:0] c);
    int idx;
    idx = -1;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) idx = int'(c - CHAR_UPPER_A);
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) idx = int'(c - CHAR_LOWER_A);
    if (idx >= 0 && tally[idx] != {OUT_COUNT_W{1'b1}}) tally[idx] = tally[idx] + 1'b1;
  endfunction

  // Ranks the nonzero counters, largest first and alphabetical on ties, queues one
  // beat per letter, then clears the counters.
  function automatic void rank_and_clear();
    logic [NUM_LETTERS-1:0] taken;
    int pick;
    int n;
    ranked_entry_t e;
    taken = '0;
    n = 0;
    forever begin
      pick = -1;
      for (int i = 0; i < NUM_LETTERS; i++) begin
        if (!taken[i] && tally[i] != 0 && (pick < 0 || tally[i] > tally[pick])) pick = i;
      end
      if (pick < 0) break;
      taken[pick] = 1'b1;
      e.letter = LETTER_W'(pick);
      e.count = tally[pick];
      e.last = 1'b0;
      ranked_q.push_back(e);
      n++;
    end
    if (n == 0) begin
      e.letter = '0;
      e.count = '0;
      e.last = 1'b1;
      ranked_q.push_back(e);
    end else begin
      ranked_q[ranked_q.size() - 1].last = 1'b1;
    end
    for (int i = 0; i < NUM_LETTERS; i++) tally[i] = '0;
  endfunction

  // Sends one input beat, updates the prediction on acceptance, then idles at random unless tx_steady is set.
  task automatic send_beat(logic op, logic [CHAR_W-1:0] ch);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    char_code <= ch;
    do @(posedge clk); while (!in_ready);
    if (op == OP_REPORT) rank_and_clear();
    else tally_char(ch);
    gap = tx_steady ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_letter(int idx, bit upper);
    send_beat(OP_COUNT, (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(idx));
  endtask

  task automatic drain_results();
    while (ranked_q.size() != 0) @(posedge clk);
  endtask

  // Reports with nothing counted, including one straight after another.
  task automatic test_empty_report();
    send_beat(OP_REPORT, 8'hFF);
    send_beat(OP_REPORT, 8'h00);
  endtask

  // Both cases fold to one letter, bytes next to the letter ranges and high bytes are
  // ignored, and equal counts come out in alphabetical order.
  task automatic test_case_and_bounds();
    send_beat(OP_COUNT, 8'h40);
    send_beat(OP_COUNT, CHAR_UPPER_A);
    send_beat(OP_COUNT, CHAR_LOWER_Z);
    send_beat(OP_COUNT, 8'h5B);
    send_beat(OP_COUNT, 8'h60);
    send_beat(OP_COUNT, CHAR_LOWER_A);
    send_beat(OP_COUNT, 8'h7B);
    send_beat(OP_COUNT, CHAR_UPPER_Z);
    send_beat(OP_COUNT, 8'hC1);
    send_beat(OP_COUNT, 8'hE1);
    send_beat(OP_COUNT, 8'h00);
    send_beat(OP_COUNT, 8'hFF);
    send_letter(1, 1'b0);
    send_letter(1, 1'b1);
    send_letter(2, 1'b1);
    send_beat(OP_REPORT, 8'h41);
  endtask

  // Every letter present, so the report runs the full length of the alphabet.
  task automatic test_all_letters();
    for (int l = NUM_LETTERS - 1; l >= 0; l--) begin
      for (int k = 0; k <= l % 3; k++) send_letter(l, (l + k) % 2 == 0);
    end
    send_beat(OP_REPORT, 8'h00);
  endtask

  // One counter driven hard with back-to-back beats, so the queue runs at full rate.
  task automatic test_full_rate_run();
    tx_steady = 1'b1;
    send_letter(4, 1'b0);
    send_letter(4, 1'b1);
    for (int k = 0; k < 40; k++) send_letter(16, k[0]);
    tx_steady = 1'b0;
    send_beat(OP_REPORT, 8'h7F);
  endtask

  // Random text over a varying slice of the alphabet so that ties are common, mixed
  // with arbitrary bytes and occasional reports.
  task automatic test_random_text();
    int span;
    int r;
    span = 4;
    for (int i = 0; i < 300; i++) begin
      if (i == 150) begin
        @(negedge clk);
        in_valid <= 1'b0;
        drain_results();
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_beat(OP_REPORT, CHAR_W'($urandom_range(0, 255)));
        case ($urandom_range(0, 2))
          0: span = 1;
          1: span = 5;
          default: span = NUM_LETTERS - 1;
        endcase
        tx_steady = ($urandom_range(0, 3) == 0);
      end else if (r < 82) begin
        send_letter($urandom_range(0, span), ($urandom_range(0, 1) == 1));
      end else begin
        send_beat(OP_COUNT, CHAR_W'($urandom_range(0, 255)));
      end
    end
    tx_steady = 1'b0;
    send_beat(OP_REPORT, 8'h80);
  endtask

  // Receiver: random stalls, switching now and then to stretches without any.
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_steady <= ($urandom_range(0, 3) == 0);
      rx_phase_left <= $urandom_range(50, 400);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_steady) rx_hold <= gap_len();
    end
  end

  // Checks each accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (ranked_q.size() == 0) begin
        $error("unexpected result beat: letter %0d count %0d last %0d", letter, count, last);
        fails++;
      end else begin
        want = ranked_q.pop_front();
        if (letter !== want.letter) begin
          $error("letter mismatch: expected %0d, got %0d", want.letter, letter);
          fails++;
        end
        if (count !== want.count) begin
          $error("count mismatch: expected %0d, got %0d", want.count, count);
          fails++;
        end
        if (last !== want.last) begin
          $error("last mismatch: expected %0d, got %0d", want.last, last);
          fails++;
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #8ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Test sequence.
  initial begin
    for (int i = 0; i < NUM_LETTERS; i++) tally[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_report();
    test_case_and_bounds();
    test_all_letters();
    test_full_rate_run();
    test_random_text();
    @(negedge clk);
    in_valid <= 1'b0;
    drain_results();
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
sv/lfr_pkg.sv
sv/lfr_front.sv
sv/lfr_fifo.sv
sv/lfr_back.sv
sv/letter_frequency_ranker.sv
test/letter_frequency_ranker_tb.sv
